// ===== sv/uaf_pkg.sv =====
// Shared types, widths and constants for the ultrasonic altitude filter.
// Also holds the elaboration-time cosine series used to build the lookup ROM.
// No dependencies.
`default_nettype none

package uaf_pkg;

    localparam int DIST_W    = 16;
    localparam int ANGLE_W   = 16;
    localparam int COS_W     = 16;
    localparam int RATE_W    = 10;
    localparam int VEL_W     = 18;
    localparam int RAW_MAG_W = DIST_W + RATE_W;

    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 16;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int COMP_LSB  = 30;

    localparam int ANGLE_FULL    = 36000;
    localparam int ANGLE_HALF    = 18000;
    localparam int ANGLE_QUARTER = 9000;
    localparam int INDEX_ROUND   = 4500;
    localparam int QUARTER_W     = 14;
    localparam int MAG_W         = ANGLE_W + 1;

    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam int     TAYLOR_TERMS = 9;
    localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};
    localparam longint COS_ONE      = 64'sd32768;

    localparam int VEL_POS_MAX = 131071;
    localparam int VEL_NEG_MAG = 131072;

    localparam logic [DIST_W-1:0] RESET_REJECT_LIMIT = 16'd5000;
    localparam logic [DIST_W-1:0] RESET_HOLD_LIMIT   = 16'd4000;
    localparam logic [RATE_W-1:0] RESET_RATE_SCALE   = 10'd20;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - VEL_W - DIST_W;

    localparam logic [1:0] REG_REJECT_LIMIT = 2'd0;
    localparam logic [1:0] REG_HOLD_LIMIT   = 2'd1;
    localparam logic [1:0] REG_RATE_SCALE   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG_P,
        ST_LOOK_P,
        ST_ANG_R,
        ST_LOOK_R,
        ST_MUL_P,
        ST_MUL_R,
        ST_FILT,
        ST_MUL_V,
        ST_DONE
    } uaf_state_t;

    typedef enum logic [1:0] {
        ANG_IDLE,
        ANG_FOLD,
        ANG_SCALE,
        ANG_DIV
    } ang_state_t;

    typedef struct packed {
        logic done;
        logic neg;
    } ang_status_t;

    // cos(x) for x in Q30, result Q1.15, from ten series terms
    function automatic logic [COS_W-1:0] cos_from_x(input longint x);
        longint x2;
        longint term;
        longint sum;
        int     k;
        x2   = (x * x) >>> 30;
        term = 64'sd1 <<< 30;
        sum  = term;
        for (k = 0; k < TAYLOR_TERMS; k++)
        begin
            term = (term * x2) >>> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0])
            begin
                sum = sum + term;
            end
            else
            begin
                sum = sum - term;
            end
        end
        if (sum < 0)
        begin
            return '0;
        end
        sum = (sum + (64'sd1 <<< 14)) >>> 15;
        if (sum > COS_ONE)
        begin
            sum = COS_ONE;
        end
        return COS_W'(sum);
    endfunction

endpackage

`default_nettype wire

// ===== sv/ultrasonic_altitude_filter.sv =====
// Tilt-compensated ultrasonic altimeter with two-tap averaging.
// Instantiates uaf_angle_index, uaf_cos_rom and uaf_serial_mult; uses uaf_pkg.
//
// Usage:
//   s_* beats carry one sensor byte with the current pitch and roll. Bytes pair
//   up high then low; a high-byte beat only stores the byte. Each low-byte beat
//   yields one m_* beat: altitude and velocity in tdata, restart flag in tuser.
//   Registers on the APB port (0x0 reject limit, 0x4 hold limit, 0x8 rate
//   scale) must be written only while no frame is in flight; the block does not check.
// Sequence:
//   A low-byte beat runs the angle divider twice (dividend width DW = bit
//   width of 9000*N + 4500, 22 at N = 256) and the bit-serial multiplier
//   three times before its result is registered. A rejected frame skips
//   both and goes straight to ST_DONE, which sends its result once the
//   output is free. s_tready is high only between frames.
// Reset and stall:
//   Reset restores the register defaults and clears the byte pairing and all
//   filter history. A result waiting on m_tready does not block the next
//   beats; the following result holds in its last step until the output frees.
`default_nettype none

module ultrasonic_altitude_filter #(
    parameter int COS_TABLE_ENTRIES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // rx_byte [7:0], pitch_angle [23:8], roll_angle [39:24]
    input  wire logic [uaf_pkg::S_TDATA_W-1:0]   s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // altitude_mm [15:0], velocity_mm_s [33:16], zero [39:34]
    output      logic [uaf_pkg::M_TDATA_W-1:0]   m_tdata,
    // restart_request [0]
    output      logic                            m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [uaf_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [uaf_pkg::PDATA_W-1:0]     pwdata,
    output      logic [uaf_pkg::PDATA_W-1:0]     prdata,
    output      logic                            pready
);

    localparam int IDX_W   = $clog2(COS_TABLE_ENTRIES + 1);
    localparam int DIST_W  = uaf_pkg::DIST_W;
    localparam int COS_W   = uaf_pkg::COS_W;
    localparam int RATE_W  = uaf_pkg::RATE_W;
    localparam int VEL_W   = uaf_pkg::VEL_W;
    localparam int ANGLE_W = uaf_pkg::ANGLE_W;
    localparam int RMAG_W  = uaf_pkg::RAW_MAG_W;
    localparam int A_W     = uaf_pkg::MUL_A_W;
    localparam int B_W     = uaf_pkg::MUL_B_W;
    localparam int P_W     = uaf_pkg::MUL_P_W;

    uaf_pkg::uaf_state_t state_reg, state_next;
    logic                phase_reg, phase_next;
    logic [DIST_W-1:0]   reject_limit_reg, reject_limit_next;
    logic [DIST_W-1:0]   hold_limit_reg, hold_limit_next;
    logic [RATE_W-1:0]   rate_scale_reg, rate_scale_next;
    logic [DIST_W-1:0]   last_good_reg, last_good_next;
    logic [DIST_W-1:0]   prev_comp_reg, prev_comp_next;
    logic [DIST_W-1:0]   prev_alt_reg, prev_alt_next;
    logic [VEL_W-1:0]    prev_raw_reg, prev_raw_next;
    logic                out_valid_reg, out_valid_next;

    logic [7:0]          high_byte_reg, high_byte_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [ANGLE_W-1:0]  roll_reg, roll_next;
    logic [COS_W-1:0]    cos_p_reg, cos_p_next;
    logic [COS_W-1:0]    cos_r_reg, cos_r_next;
    logic                neg_p_reg, neg_p_next;
    logic                neg_r_reg, neg_r_next;
    logic [DIST_W-1:0]   comp_reg, comp_next;
    logic [DIST_W-1:0]   alt_reg, alt_next;
    logic                diff_neg_reg, diff_neg_next;
    logic [VEL_W-1:0]    raw_reg, raw_next;
    logic                rej_reg, rej_next;
    logic                out_restart_reg, out_restart_next;
    logic [DIST_W-1:0]   out_alt_reg, out_alt_next;
    logic [VEL_W-1:0]    out_vel_reg, out_vel_next;

    logic [7:0]          in_byte;
    logic [ANGLE_W-1:0]  in_pitch;
    logic [ANGLE_W-1:0]  in_roll;
    logic [DIST_W-1:0]   frame_dist;
    logic                in_beat;
    logic                cfg_we;

    logic                ang_start;
    logic [ANGLE_W-1:0]  ang_angle;
    logic [IDX_W-1:0]    ang_index;
    uaf_pkg::ang_status_t ang_st;
    logic [COS_W-1:0]    rom_data;

    logic                mul_start;
    logic [A_W-1:0]      mul_a;
    logic [B_W-1:0]      mul_b;
    logic                mul_done;
    logic [P_W-1:0]      mul_prod;

    logic [DIST_W:0]     alt_sum;
    logic [DIST_W-1:0]   alt_calc;
    logic [DIST_W-1:0]   diff_mag;
    logic [DIST_W-1:0]   comp_calc;
    logic [RMAG_W-1:0]   raw_mag;
    logic [VEL_W-1:0]    raw_calc;
    logic [VEL_W:0]      vel_sum;
    logic [VEL_W:0]      vel_adj;
    logic [VEL_W-1:0]    vel_calc;
    logic                out_free;

    assign in_byte    = s_tdata[7:0];
    assign in_pitch   = s_tdata[8 +: ANGLE_W];
    assign in_roll    = s_tdata[8 + ANGLE_W +: ANGLE_W];
    assign frame_dist = {high_byte_reg, in_byte};
    assign s_tready   = (state_reg == uaf_pkg::ST_IDLE);
    assign in_beat    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign cfg_we     = psel && penable && pwrite && pready;
    assign ang_angle  = (state_reg == uaf_pkg::ST_IDLE) ? in_pitch : roll_reg;

    uaf_angle_index #(
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_angle (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ang_start),
        .angle  (ang_angle),
        .index  (ang_index),
        .status (ang_st)
    );

    uaf_cos_rom #(
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_rom (
        .clk  (clk),
        .addr (ang_index),
        .data (rom_data)
    );

    uaf_serial_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        alt_sum   = {1'b0, comp_reg} + {1'b0, prev_comp_reg};
        alt_calc  = alt_sum[DIST_W:1];
        diff_mag  = (alt_calc >= prev_alt_reg) ? alt_calc - prev_alt_reg
                                               : prev_alt_reg - alt_calc;
        comp_calc = (neg_p_reg ^ neg_r_reg) ? '0 : mul_prod[uaf_pkg::COMP_LSB +: DIST_W];
        raw_mag   = mul_prod[RMAG_W-1:0];
        if (!diff_neg_reg)
        begin
            raw_calc = (raw_mag > RMAG_W'(uaf_pkg::VEL_POS_MAX))
                       ? VEL_W'(uaf_pkg::VEL_POS_MAX) : VEL_W'(raw_mag);
        end
        else if (raw_mag > RMAG_W'(uaf_pkg::VEL_NEG_MAG))
        begin
            raw_calc = VEL_W'(uaf_pkg::VEL_NEG_MAG);
        end
        else
        begin
            raw_calc = VEL_W'(0) - VEL_W'(raw_mag);
        end
        // truncate toward zero on halving
        vel_sum  = {raw_reg[VEL_W-1], raw_reg} + {prev_raw_reg[VEL_W-1], prev_raw_reg};
        vel_adj  = vel_sum + {{VEL_W{1'b0}}, vel_sum[VEL_W]};
        vel_calc = vel_adj[VEL_W:1];
    end

    always_comb
    begin
        reject_limit_next = reject_limit_reg;
        hold_limit_next   = hold_limit_reg;
        rate_scale_next   = rate_scale_reg;
        if (cfg_we)
        begin
            unique case (paddr[3:2])
                uaf_pkg::REG_REJECT_LIMIT: reject_limit_next = pwdata[DIST_W-1:0];
                uaf_pkg::REG_HOLD_LIMIT:   hold_limit_next   = pwdata[DIST_W-1:0];
                uaf_pkg::REG_RATE_SCALE:   rate_scale_next   = pwdata[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            uaf_pkg::REG_REJECT_LIMIT: prdata = uaf_pkg::PDATA_W'(reject_limit_reg);
            uaf_pkg::REG_HOLD_LIMIT:   prdata = uaf_pkg::PDATA_W'(hold_limit_reg);
            uaf_pkg::REG_RATE_SCALE:   prdata = uaf_pkg::PDATA_W'(rate_scale_reg);
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        last_good_next   = last_good_reg;
        prev_comp_next   = prev_comp_reg;
        prev_alt_next    = prev_alt_reg;
        prev_raw_next    = prev_raw_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        high_byte_next   = high_byte_reg;
        dist_next        = dist_reg;
        roll_next        = roll_reg;
        cos_p_next       = cos_p_reg;
        cos_r_next       = cos_r_reg;
        neg_p_next       = neg_p_reg;
        neg_r_next       = neg_r_reg;
        comp_next        = comp_reg;
        alt_next         = alt_reg;
        diff_neg_next    = diff_neg_reg;
        raw_next         = raw_reg;
        rej_next         = rej_reg;
        out_restart_next = out_restart_reg;
        out_alt_next     = out_alt_reg;
        out_vel_next     = out_vel_reg;
        ang_start        = 1'b0;
        mul_start        = 1'b0;
        mul_a            = A_W'(dist_reg);
        mul_b            = cos_p_reg;

        unique case (state_reg)
            uaf_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (!phase_reg)
                    begin
                        high_byte_next = in_byte;
                        phase_next     = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (frame_dist > reject_limit_reg)
                        begin
                            rej_next   = 1'b1;
                            state_next = uaf_pkg::ST_DONE;
                        end
                        else
                        begin
                            rej_next = 1'b0;
                            if (frame_dist > hold_limit_reg)
                            begin
                                dist_next = last_good_reg;
                            end
                            else
                            begin
                                dist_next      = frame_dist;
                                last_good_next = frame_dist;
                            end
                            roll_next  = in_roll;
                            ang_start  = 1'b1;
                            state_next = uaf_pkg::ST_ANG_P;
                        end
                    end
                end
            end
            uaf_pkg::ST_ANG_P:
            begin
                if (ang_st.done)
                begin
                    state_next = uaf_pkg::ST_LOOK_P;
                end
            end
            uaf_pkg::ST_LOOK_P:
            begin
                cos_p_next = rom_data;
                neg_p_next = ang_st.neg;
                ang_start  = 1'b1;
                state_next = uaf_pkg::ST_ANG_R;
            end
            uaf_pkg::ST_ANG_R:
            begin
                if (ang_st.done)
                begin
                    state_next = uaf_pkg::ST_LOOK_R;
                end
            end
            uaf_pkg::ST_LOOK_R:
            begin
                cos_r_next = rom_data;
                neg_r_next = ang_st.neg;
                mul_start  = 1'b1;
                state_next = uaf_pkg::ST_MUL_P;
            end
            uaf_pkg::ST_MUL_P:
            begin
                mul_a = mul_prod[A_W-1:0];
                mul_b = cos_r_reg;
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = uaf_pkg::ST_MUL_R;
                end
            end
            uaf_pkg::ST_MUL_R:
            begin
                if (mul_done)
                begin
                    comp_next  = comp_calc;
                    state_next = uaf_pkg::ST_FILT;
                end
            end
            uaf_pkg::ST_FILT:
            begin
                mul_a         = A_W'(diff_mag);
                mul_b         = B_W'(rate_scale_reg);
                mul_start     = 1'b1;
                alt_next      = alt_calc;
                diff_neg_next = alt_calc < prev_alt_reg;
                state_next    = uaf_pkg::ST_MUL_V;
            end
            uaf_pkg::ST_MUL_V:
            begin
                if (mul_done)
                begin
                    raw_next   = raw_calc;
                    state_next = uaf_pkg::ST_DONE;
                end
            end
            uaf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (rej_reg)
                    begin
                        out_restart_next = 1'b1;
                        out_alt_next     = '0;
                        out_vel_next     = '0;
                    end
                    else
                    begin
                        out_restart_next = 1'b0;
                        out_alt_next     = alt_reg;
                        out_vel_next     = vel_calc;
                        prev_comp_next   = comp_reg;
                        prev_alt_next    = alt_reg;
                        prev_raw_next    = raw_reg;
                    end
                    state_next = uaf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= uaf_pkg::ST_IDLE;
            phase_reg        <= 1'b0;
            reject_limit_reg <= uaf_pkg::RESET_REJECT_LIMIT;
            hold_limit_reg   <= uaf_pkg::RESET_HOLD_LIMIT;
            rate_scale_reg   <= uaf_pkg::RESET_RATE_SCALE;
            last_good_reg    <= '0;
            prev_comp_reg    <= '0;
            prev_alt_reg     <= '0;
            prev_raw_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            reject_limit_reg <= reject_limit_next;
            hold_limit_reg   <= hold_limit_next;
            rate_scale_reg   <= rate_scale_next;
            last_good_reg    <= last_good_next;
            prev_comp_reg    <= prev_comp_next;
            prev_alt_reg     <= prev_alt_next;
            prev_raw_reg     <= prev_raw_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        high_byte_reg   <= high_byte_next;
        dist_reg        <= dist_next;
        roll_reg        <= roll_next;
        cos_p_reg       <= cos_p_next;
        cos_r_reg       <= cos_r_next;
        neg_p_reg       <= neg_p_next;
        neg_r_reg       <= neg_r_next;
        comp_reg        <= comp_next;
        alt_reg         <= alt_next;
        diff_neg_reg    <= diff_neg_next;
        raw_reg         <= raw_next;
        rej_reg         <= rej_next;
        out_restart_reg <= out_restart_next;
        out_alt_reg     <= out_alt_next;
        out_vel_reg     <= out_vel_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_restart_reg;
    assign m_tdata  = {{uaf_pkg::M_PAD_W{1'b0}}, out_vel_reg, out_alt_reg};

    ap_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("restart beat carries nonzero data");

    ap_ang_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ang_st.done |-> (state_reg == uaf_pkg::ST_ANG_P || state_reg == uaf_pkg::ST_ANG_R))
        else $error("angle index finished outside a lookup wait");

    ap_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == uaf_pkg::ST_MUL_P || state_reg == uaf_pkg::ST_MUL_R
                      || state_reg == uaf_pkg::ST_MUL_V))
        else $error("multiplier finished outside a multiply wait");

    ap_low_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && phase_reg |=> !s_tready)
        else $error("input taken while a frame is in flight");

endmodule

`default_nettype wire

// ===== sv/uaf_cos_rom.sv =====
// Quarter-wave cosine ROM in Q1.15 with a registered read port.
// Contents are built at elaboration from uaf_pkg::cos_from_x.
// Depends on uaf_pkg.
`default_nettype none

module uaf_cos_rom #(
    parameter int COS_TABLE_ENTRIES = 256,
    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1)
) (
    input  wire logic                     clk,
    input  wire logic [IDX_W-1:0]         addr,
    output      logic [uaf_pkg::COS_W-1:0] data
);

    typedef logic [uaf_pkg::COS_W-1:0] rom_arr_t [COS_TABLE_ENTRIES + 1];

    function automatic rom_arr_t build_rom();
        rom_arr_t t;
        longint   x;
        int       i;
        for (i = 0; i <= COS_TABLE_ENTRIES; i++)
        begin
            x    = (longint'(i) * uaf_pkg::HALF_PI_Q30) / COS_TABLE_ENTRIES;
            t[i] = uaf_pkg::cos_from_x(x);
        end
        return t;
    endfunction

    localparam rom_arr_t ROM = build_rom();

    logic [uaf_pkg::COS_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== sv/uaf_angle_index.sv =====
// Angle to cosine-table index: folds the angle into one quadrant, then
// divides by the quadrant span one quotient bit per cycle.
// Depends on uaf_pkg.
`default_nettype none

module uaf_angle_index #(
    parameter int COS_TABLE_ENTRIES = 256,
    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [uaf_pkg::ANGLE_W-1:0]  angle,
    output      logic [IDX_W-1:0]             index,
    output      uaf_pkg::ang_status_t         status
);

    localparam int DIV_W = $clog2(uaf_pkg::ANGLE_QUARTER * COS_TABLE_ENTRIES
                                  + uaf_pkg::INDEX_ROUND + 1);
    localparam int CNT_W    = $clog2(DIV_W + 1);
    localparam int REM_W    = uaf_pkg::QUARTER_W;
    localparam int REM_SH_W = REM_W + 1;
    localparam int MAG_W    = uaf_pkg::MAG_W;

    uaf_pkg::ang_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [REM_W-1:0]    fold_reg, fold_next;
    logic                neg_reg, neg_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    q_reg, q_next;

    logic [MAG_W-1:0]    mag_ext;
    logic [MAG_W-1:0]    mag_abs;
    logic [MAG_W-1:0]    fold1;
    logic                fold_neg;
    logic [MAG_W-1:0]    fold2;
    logic [REM_SH_W-1:0] rem_sh;
    logic                rem_ge;

    always_comb
    begin
        mag_ext  = {angle[uaf_pkg::ANGLE_W-1], angle};
        mag_abs  = angle[uaf_pkg::ANGLE_W-1] ? (~mag_ext + 1'b1) : mag_ext;
        fold1    = (mag_reg > MAG_W'(uaf_pkg::ANGLE_HALF))
                   ? MAG_W'(uaf_pkg::ANGLE_FULL) - mag_reg : mag_reg;
        fold_neg = fold1 > MAG_W'(uaf_pkg::ANGLE_QUARTER);
        fold2    = fold_neg ? MAG_W'(uaf_pkg::ANGLE_HALF) - fold1 : fold1;
        rem_sh   = {rem_reg, div_reg[DIV_W-1]};
        rem_ge   = rem_sh >= REM_SH_W'(uaf_pkg::ANGLE_QUARTER);

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mag_next   = mag_reg;
        fold_next  = fold_reg;
        neg_next   = neg_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;

        if (start)
        begin
            mag_next   = mag_abs;
            state_next = uaf_pkg::ANG_FOLD;
        end
        else
        begin
            unique case (state_reg)
                uaf_pkg::ANG_IDLE:
                begin
                end
                uaf_pkg::ANG_FOLD:
                begin
                    fold_next  = REM_W'(fold2);
                    neg_next   = fold_neg;
                    state_next = uaf_pkg::ANG_SCALE;
                end
                uaf_pkg::ANG_SCALE:
                begin
                    div_next   = DIV_W'(fold_reg) * DIV_W'(COS_TABLE_ENTRIES)
                                 + DIV_W'(uaf_pkg::INDEX_ROUND);
                    rem_next   = '0;
                    cnt_next   = CNT_W'(DIV_W);
                    state_next = uaf_pkg::ANG_DIV;
                end
                uaf_pkg::ANG_DIV:
                begin
                    rem_next = rem_ge ? REM_W'(rem_sh - REM_SH_W'(uaf_pkg::ANGLE_QUARTER))
                                      : rem_sh[REM_W-1:0];
                    div_next = div_reg << 1;
                    q_next   = {q_reg[IDX_W-2:0], rem_ge};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        done_next  = 1'b1;
                        state_next = uaf_pkg::ANG_IDLE;
                    end
                end
                default:
                begin
                    state_next = uaf_pkg::ANG_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uaf_pkg::ANG_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        fold_reg <= fold_next;
        neg_reg  <= neg_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign index       = q_reg;
    assign status.done = done_reg;
    assign status.neg  = neg_reg;

endmodule

`default_nettype wire

// ===== sv/uaf_serial_mult.sv =====
// Shift-add multiplier: one multiplier bit per cycle, 32 x 16 to 48 bits.
// Depends on uaf_pkg.
`default_nettype none

module uaf_serial_mult (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [uaf_pkg::MUL_A_W-1:0]   a,
    input  wire logic [uaf_pkg::MUL_B_W-1:0]   b,
    output      logic                          done,
    output      logic [uaf_pkg::MUL_P_W-1:0]   prod
);

    localparam int A_W   = uaf_pkg::MUL_A_W;
    localparam int B_W   = uaf_pkg::MUL_B_W;
    localparam int P_W   = uaf_pkg::MUL_P_W;
    localparam int CNT_W = uaf_pkg::MUL_CNT_W;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [P_W-1:0]   prod_reg, prod_next;
    logic [A_W:0]     step_sum;

    always_comb
    begin
        step_sum  = {1'b0, prod_reg[P_W-1:B_W]}
                    + (prod_reg[0] ? {1'b0, a_reg} : {(A_W + 1){1'b0}});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        prod_next = prod_reg;
        if (start)
        begin
            a_next    = a;
            prod_next = {{A_W{1'b0}}, b};
            cnt_next  = CNT_W'(B_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {step_sum, prod_reg[B_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire
